// ===== hdl/qodo_pkg.sv =====
// package for quadrature odometry: constants, types, decode table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package qodo_pkg;
	localparam int unsigned CordicStepsDef = 24;
	localparam logic [31:0] MptReset = 32'd2436245;
	localparam logic [31:0] AptReset = 32'd1685830;
	localparam logic [31:0] CordicGain = 32'd652032874;
	localparam logic signed [33:0] Q30One = 34'sd1073741824;
	localparam logic OpPins = 1'b0;
	localparam logic OpUpdate = 1'b1;
	localparam logic [0:0] RegMpt = 1'b0;
	localparam logic [0:0] RegApt = 1'b1;

	function automatic logic [1:0] step_code(input logic [3:0] idx);
		// 2'b01 = +1, 2'b11 = -1, else 0
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: step_code = 2'b11;
			4'd2, 4'd4, 4'd11, 4'd13: step_code = 2'b01;
			default: step_code = 2'b00;
		endcase
	endfunction

	function automatic logic [31:0] atan_val(input logic [4:0] i);
		case (i)
			5'd0: atan_val = 32'h20000000; 5'd1: atan_val = 32'h12E4051E;
			5'd2: atan_val = 32'h09FB385B; 5'd3: atan_val = 32'h051111D4;
			5'd4: atan_val = 32'h028B0D43; 5'd5: atan_val = 32'h0145D7E1;
			5'd6: atan_val = 32'h00A2F61E; 5'd7: atan_val = 32'h00517C55;
			5'd8: atan_val = 32'h0028BE53; 5'd9: atan_val = 32'h00145F2F;
			5'd10: atan_val = 32'h000A2F98; 5'd11: atan_val = 32'h000517CC;
			5'd12: atan_val = 32'h00028BE6; 5'd13: atan_val = 32'h000145F3;
			5'd14: atan_val = 32'h0000A2FA; 5'd15: atan_val = 32'h0000517D;
			5'd16: atan_val = 32'h000028BE; 5'd17: atan_val = 32'h0000145F;
			5'd18: atan_val = 32'h00000A30; 5'd19: atan_val = 32'h00000518;
			5'd20: atan_val = 32'h0000028C; 5'd21: atan_val = 32'h00000146;
			5'd22: atan_val = 32'h000000A3; 5'd23: atan_val = 32'h00000051;
			5'd24: atan_val = 32'h00000029; 5'd25: atan_val = 32'h00000014;
			5'd26: atan_val = 32'h0000000A; 5'd27: atan_val = 32'h00000005;
			5'd28: atan_val = 32'h00000003; 5'd29: atan_val = 32'h00000001;
			5'd30: atan_val = 32'h00000001;
			default: atan_val = 32'h00000000;
		endcase
	endfunction

	typedef struct packed {
		logic        opcode;
		logic        left_a;
		logic        left_b;
		logic        right_a;
		logic        right_b;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [22:0]        stamp_seconds;
		logic [29:0]        stamp_nanoseconds;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] orient_z;
		logic signed [31:0] orient_w;
		logic signed [31:0] linear_rate;
		logic signed [31:0] angular_rate;
	} out_item_t;
endpackage
`default_nettype wire

// ===== hdl/qodo_if.sv =====
// valid/ready channel carrying one payload item
// payload type given as a type parameter
`timescale 1ns / 1ps
`default_nettype none
interface qodo_if #(parameter type item_t = logic) ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/qodo_cordic.sv =====
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on qodo_pkg
`timescale 1ns / 1ps
`default_nettype none
module qodo_cordic #(
	parameter int unsigned CORDIC_STEPS = qodo_pkg::CordicStepsDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [31:0]        angle,
	output logic                    done,
	output logic signed [31:0]      cos_out,
	output logic signed [31:0]      sin_out
);
	import qodo_pkg::*;
	localparam int CW = $clog2(CORDIC_STEPS + 1);
	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic [CW-1:0] i_q;
	logic busy_q, flip_q;
	logic [31:0] a2;
	logic [4:0] sh;
	logic signed [33:0] dx, dy, xf, yf;

	assign sh = i_q[4:0];
	assign dx = y_q >>> sh;
	assign dy = x_q >>> sh;
	assign a2 = (angle[31] ^ angle[30]) ? angle + 32'h80000000 : angle;
	assign xf = flip_q ? -x_q : x_q;
	assign yf = flip_q ? -y_q : y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
				flip_q <= angle[31] ^ angle[30];
				x_q <= {2'b00, CordicGain};
				y_q <= '0;
				z_q <= {a2[31], a2};
			end else if (busy_q) begin
				if (i_q == CW'(CORDIC_STEPS)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
					cos_out <= (xf > Q30One) ? 32'sd1073741824 :
						(xf < -Q30One) ? -32'sd1073741824 : xf[31:0];
					sin_out <= (yf > Q30One) ? 32'sd1073741824 :
						(yf < -Q30One) ? -32'sd1073741824 : yf[31:0];
				end else begin
					i_q <= i_q + 1'b1;
					if (!z_q[32]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - $signed({1'b0, atan_val(sh)});
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + $signed({1'b0, atan_val(sh)});
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/qodo_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module qodo_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [31:0] den,
	output logic             done,
	output logic [63:0]      quo
);
	logic [63:0] n_q;
	logic [32:0] r_q;
	logic [6:0] c_q;
	logic busy_q;
	logic [32:0] rs;
	logic [33:0] diff;

	assign rs = {r_q[31:0], n_q[63]};
	assign diff = {1'b0, rs} - {2'b00, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			c_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q <= num;
				r_q <= '0;
				c_q <= '0;
			end else if (busy_q) begin
				if (!diff[33]) begin
					r_q <= diff[32:0];
					n_q <= {n_q[62:0], 1'b1};
				end else begin
					r_q <= rs;
					n_q <= {n_q[62:0], 1'b0};
				end
				c_q <= c_q + 1'b1;
				if (c_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	assign quo = n_q;
endmodule
`default_nettype wire

// ===== hdl/quadrature_odometry.sv =====
// quadrature odometry top: decoders, apb registers, update sequencer
// depends on qodo_pkg, qodo_if, qodo_cordic, qodo_div
//
// channel  dir  payload
// in_ch    in   opcode, pin levels, now_ms
// out_ch   out  stamp, pose, quaternion, rates
// cfg      in   apb, two 32-bit registers
//
// a pin item, or an update with an unchanged time, is handled in the idle state.
// an update runs the sequencer through the shared cordic (two trig pairs)
// and the bit-serial divider (two rate quotients) before its result is
// valid; seconds use a reciprocal.
// reset clears sequencer, tick counts and pose; registers go to defaults.
// the result is held in an output register until taken; in_ch is not
// ready while an item is worked on or a result waits.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_odometry #(
	parameter int unsigned CORDIC_STEPS = qodo_pkg::CordicStepsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	qodo_if.sink             in_ch,
	qodo_if.source           out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:2]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import qodo_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_PREP, S_MUL1, S_MUL2, S_CMID, S_WMID, S_ADVX, S_ADVY,
		S_CHH, S_WHH, S_DS, S_WS, S_DLR, S_WLR, S_DAR, S_WAR, S_OUT
	} state_t;

	state_t state_q;
	logic [31:0] mpt_q, apt_q;
	logic [31:0] lt_q, rt_q, plt_q, prt_q, ptime_q, xp_q, yp_q, hd_q;
	logic [1:0] lph_q, rph_q;
	logic [31:0] now_q, el_q;
	logic sneg_q, hneg_q;
	logic [32:0] smag_q, hmag_q;
	logic [63:0] dmag_q, p_q;
	logic [31:0] dh_q, half_q;
	logic signed [31:0] cs_q, sn_q;
	logic [22:0] sec_q;
	out_item_t res_q;
	logic out_v_q;

	logic cstart, cdone, dstart, ddone;
	logic [31:0] cang;
	logic signed [31:0] ccos, csin;
	logic [63:0] dnum, dquo;
	logic [31:0] dden;

	qodo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .start(cstart), .angle(cang), .done(cdone),
		.cos_out(ccos), .sin_out(csin));
	qodo_div u_div (
		.clk, .arst_n, .start(dstart), .num(dnum), .den(dden), .done(ddone),
		.quo(dquo));

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegApt) ? apt_q : mpt_q;
	assign in_ch.ready = (state_q == S_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = res_q;

	// differences
	logic [31:0] dl, dr;
	logic signed [32:0] sum, dif;
	assign dl = lt_q - plt_q;
	assign dr = rt_q - prt_q;
	assign sum = $signed({dl[31], dl}) + $signed({dr[31], dr});
	assign dif = $signed({dr[31], dr}) - $signed({dl[31], dl});

	// shared advance multiplier: trig magnitude times dmag chunk
	logic signed [31:0] trig;
	logic tneg;
	logic [30:0] tmag;
	logic [63:0] pa, pb, inc;
	logic signed [33:0] rsum;
	logic [31:0] pos, newpos;
	assign trig = (state_q == S_ADVX) ? cs_q : sn_q;
	assign pos = (state_q == S_ADVX) ? xp_q : yp_q;
	assign tneg = trig[31];
	assign tmag = tneg ? 31'(-trig) : trig[30:0];
	assign pa = {33'd0, dmag_q[47:17]} * {33'd0, tmag};
	assign pb = {47'd0, dmag_q[16:0]} * {33'd0, tmag};
	assign inc = (pa >> 13) + ((({51'd0, pa[12:0]} << 17) + pb) >> 30);
	always_comb begin
		if (inc > 64'hFFFFFFFF)
			rsum = (sneg_q != tneg) ? -34'sh100000000 : 34'sh100000000;
		else if (sneg_q != tneg)
			rsum = $signed({{2{pos[31]}}, pos}) - $signed({1'b0, inc[32:0]});
		else
			rsum = $signed({{2{pos[31]}}, pos}) + $signed({1'b0, inc[32:0]});
		if (rsum > 34'sh07FFFFFFF) newpos = 32'h7FFFFFFF;
		else if (rsum < -34'sh080000000) newpos = 32'h80000000;
		else newpos = rsum[31:0];
	end

	// rate saturation
	function automatic logic [31:0] sat_rate(input logic neg, input logic big,
		input logic [63:0] q);
		logic [63:0] qq;
		qq = big ? 64'h10000000000 : q;
		if (neg) sat_rate = (qq >= 64'h80000000) ? 32'h80000000 : 32'd0 - qq[31:0];
		else sat_rate = (qq > 64'h7FFFFFFF) ? 32'h7FFFFFFF : qq[31:0];
	endfunction

	logic [31:0] hh;
	assign hh = {hd_q[31], hd_q[31:1]};

	logic [73:0] m1000_d, m1000_p;
	assign m1000_d = {10'd0, dmag_q} * 74'd1000;
	assign m1000_p = {10'd0, p_q} * 74'd1000;

	// seconds by reciprocal of 1000
	logic [63:0] sec_p;
	assign sec_p = {32'd0, now_q} * 64'd274877907;

	always_comb begin
		cstart = 1'b0;
		cang = hh;
		dstart = 1'b0;
		dnum = {32'd0, now_q};
		dden = el_q;
		case (state_q)
			S_CMID: begin cstart = 1'b1; cang = hd_q + half_q; end
			S_CHH: cstart = 1'b1;
			S_DLR: dnum = m1000_d[63:0];
			S_DAR: dnum = m1000_p[63:0];
			default: ;
		endcase
		if (state_q == S_DLR || state_q == S_DAR) dstart = 1'b1;
	end

	logic [3:0] lidx, ridx;
	logic [1:0] lstep, rstep;
	assign lidx = {lph_q, in_ch.data.left_a, in_ch.data.left_b};
	assign ridx = {rph_q, in_ch.data.right_a, in_ch.data.right_b};
	assign lstep = step_code(lidx);
	assign rstep = step_code(ridx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mpt_q <= MptReset;
			apt_q <= AptReset;
			lt_q <= '0; rt_q <= '0; plt_q <= '0; prt_q <= '0;
			ptime_q <= '0; xp_q <= '0; yp_q <= '0; hd_q <= '0;
			lph_q <= '0; rph_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2] == RegMpt) mpt_q <= pwdata;
				else apt_q <= pwdata;
			end
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					if (in_ch.data.opcode == OpPins) begin
						lt_q <= lt_q + {{30{lstep[1]}}, lstep};
						rt_q <= rt_q + {{30{rstep[1]}}, rstep};
						lph_q <= {in_ch.data.left_a, in_ch.data.left_b};
						rph_q <= {in_ch.data.right_a, in_ch.data.right_b};
					end else if (in_ch.data.now_ms != ptime_q) begin
						now_q <= in_ch.data.now_ms;
						el_q <= in_ch.data.now_ms - ptime_q;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					sneg_q <= sum[32];
					smag_q <= sum[32] ? 33'(-sum) : sum;
					hneg_q <= dif[32];
					hmag_q <= dif[32] ? 33'(-dif) : dif;
					plt_q <= lt_q;
					prt_q <= rt_q;
					ptime_q <= now_q;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					dmag_q <= ({31'd0, smag_q} * {32'd0, mpt_q}) >> 17;
					p_q <= {31'd0, hmag_q} * {32'd0, apt_q};
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					dh_q <= hneg_q ? 32'd0 - p_q[31:0] : p_q[31:0];
					half_q <= hneg_q ? 32'd0 - p_q[32:1] : p_q[32:1];
					state_q <= S_CMID;
				end
				S_CMID: state_q <= S_WMID;
				S_WMID: if (cdone) begin
					cs_q <= ccos;
					sn_q <= csin;
					state_q <= S_ADVX;
				end
				S_ADVX: begin xp_q <= newpos; state_q <= S_ADVY; end
				S_ADVY: begin
					yp_q <= newpos;
					hd_q <= hd_q + dh_q;
					state_q <= S_CHH;
				end
				S_CHH: state_q <= S_WHH;
				S_WHH: if (cdone) begin
					res_q.orient_w <= ccos;
					res_q.orient_z <= csin;
					res_q.pos_x <= xp_q;
					res_q.pos_y <= yp_q;
					state_q <= S_DS;
				end
				S_DS: begin
					sec_q <= sec_p[60:38];
					state_q <= S_WS;
				end
				S_WS: begin
					res_q.stamp_seconds <= sec_q;
					res_q.stamp_nanoseconds <=
						30'((now_q - {9'd0, sec_q} * 32'd1000) * 32'd1000000);
					state_q <= S_DLR;
				end
				S_DLR: state_q <= S_WLR;
				S_WLR: if (ddone) begin
					res_q.linear_rate <= sat_rate(sneg_q, dmag_q[63:54] != 0, dquo);
					state_q <= S_DAR;
				end
				S_DAR: state_q <= S_WAR;
				S_WAR: if (ddone) begin
					res_q.angular_rate <= sat_rate(hneg_q, p_q[63:54] != 0, dquo);
					state_q <= S_OUT;
				end
				S_OUT: if (!out_v_q) begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== dv/quadrature_odometry_tb.sv =====
// self-checking testbench for quadrature_odometry: directed and random items
// depends on qodo_pkg, qodo_if and the quadrature_odometry rtl
`timescale 1ns / 1ps
module quadrature_odometry_tb;
	import qodo_pkg::*;

	localparam int Settle = 400;
	localparam longint CycleLimit = 3000000;

	class odometry_scoreboard;
		logic [31:0] mpt, apt, lticks, rticks, last_lticks, last_rticks, last_ms;
		logic [31:0] xq, yq, hdg;
		logic [1:0]  lph, rph;
		out_item_t   poses[$];
		int          errors, results;

		function new();
			mpt = MptReset; apt = AptReset;
			lticks = 0; rticks = 0; last_lticks = 0; last_rticks = 0; last_ms = 0;
			xq = 0; yq = 0; hdg = 0; lph = 0; rph = 0;
			errors = 0; results = 0;
		endfunction

		function void write_reg(logic [0:0] idx, logic [31:0] v);
			if (idx == RegMpt) mpt = v;
			else if (idx == RegApt) apt = v;
		endfunction

		static function longint s32(logic [31:0] v);
			return longint'($signed(v));
		endfunction

		static function void sincos(input logic [31:0] ang, output longint cs,
				output longint sn);
			logic [31:0] atans [32] = '{
				32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
				32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
				32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
				32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
				32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
				32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
				32'h00000001, 32'h00000000};
			bit flip;
			longint x, y, z, dx, dy;
			flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
			if (flip) ang = ang + 32'h80000000;
			x = longint'(CordicGain); y = 0; z = s32(ang);
			for (int i = 0; i < CordicStepsDef; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(atans[i]);
				end else begin
					x += dx; y -= dy; z += longint'(atans[i]);
				end
			end
			if (flip) begin
				x = -x; y = -y;
			end
			if (x > 64'sd1073741824) x = 64'sd1073741824;
			if (x < -64'sd1073741824) x = -64'sd1073741824;
			if (y > 64'sd1073741824) y = 64'sd1073741824;
			if (y < -64'sd1073741824) y = -64'sd1073741824;
			cs = x; sn = y;
		endfunction

		static function logic [31:0] move_axis(logic [31:0] p, bit dneg, logic [63:0] dmag,
				longint trig);
			bit tneg;
			logic [63:0] tmag, a, b, prod;
			longint r;
			tneg = trig < 0;
			tmag = tneg ? -trig : trig;
			a = (dmag >> 17) * tmag;
			b = (dmag & 64'h1FFFF) * tmag;
			prod = (a >> 13) + ((((a & 64'h1FFF) << 17) + b) >> 30);
			r = s32(p) + ((dneg != tneg) ? -longint'(prod) : longint'(prod));
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			return r[31:0];
		endfunction

		static function logic [31:0] per_second(bit neg, logic [63:0] mag, logic [31:0] el);
			logic [63:0] q;
			q = (mag >= 64'h40000000000000) ? 64'h10000000000 : mag * 1000 / {32'b0, el};
			if (neg) return (q >= 64'h80000000) ? 32'h80000000 : -q[31:0];
			return (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
		endfunction

		function void note_item(in_item_t it);
			int steps [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
			logic [1:0] ln, rn;
			logic [31:0] el, hd, half, mid, hh;
			longint sum, dif, cs, sn, qz, qw;
			bit sneg, hneg;
			logic [63:0] smag, dmag, hmag, p;
			out_item_t e;
			if (it.opcode == OpPins) begin
				ln = {it.left_a, it.left_b};
				rn = {it.right_a, it.right_b};
				lticks = lticks + 32'(steps[{lph, ln}]);
				rticks = rticks + 32'(steps[{rph, rn}]);
				lph = ln; rph = rn;
				return;
			end
			if (it.now_ms == last_ms) return;
			el = it.now_ms - last_ms;
			sum = s32(lticks - last_lticks) + s32(rticks - last_rticks);
			dif = s32(rticks - last_rticks) - s32(lticks - last_lticks);
			sneg = sum < 0;
			smag = sneg ? -sum : sum;
			dmag = (smag * {32'b0, mpt}) >> 17;
			hneg = dif < 0;
			hmag = hneg ? -dif : dif;
			p = hmag * {32'b0, apt};
			hd = p[31:0];
			half = p[32:1];
			if (hneg) begin
				hd = -hd; half = -half;
			end
			mid = hdg + half;
			sincos(mid, cs, sn);
			xq = move_axis(xq, sneg, dmag, cs);
			yq = move_axis(yq, sneg, dmag, sn);
			hdg = hdg + hd;
			last_lticks = lticks; last_rticks = rticks; last_ms = it.now_ms;
			hh = {hdg[31], hdg[31:1]};
			sincos(hh, qw, qz);
			e.stamp_seconds = 23'(it.now_ms / 1000);
			e.stamp_nanoseconds = 30'(longint'(it.now_ms % 1000) * 1000000);
			e.pos_x = xq;
			e.pos_y = yq;
			e.orient_z = qz[31:0];
			e.orient_w = qw[31:0];
			e.linear_rate = per_second(sneg, dmag, el);
			e.angular_rate = per_second(hneg, p, el);
			poses.push_back(e);
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			$display("error: result %0d %s got %h expected %h", results, field, got, want);
			errors++;
		endtask

		task check_pose(out_item_t got);
			out_item_t e;
			if (poses.size() == 0) begin
				$display("error: result %0d arrived with nothing expected", results);
				errors++;
				results++;
				return;
			end
			e = poses.pop_front();
			if (got.stamp_seconds !== e.stamp_seconds)
				report("stamp_seconds", 32'(got.stamp_seconds), 32'(e.stamp_seconds));
			if (got.stamp_nanoseconds !== e.stamp_nanoseconds)
				report("stamp_nanoseconds", 32'(got.stamp_nanoseconds),
					32'(e.stamp_nanoseconds));
			if (got.pos_x !== e.pos_x) report("pos_x", got.pos_x, e.pos_x);
			if (got.pos_y !== e.pos_y) report("pos_y", got.pos_y, e.pos_y);
			if (got.orient_z !== e.orient_z) report("orient_z", got.orient_z, e.orient_z);
			if (got.orient_w !== e.orient_w) report("orient_w", got.orient_w, e.orient_w);
			if (got.linear_rate !== e.linear_rate)
				report("linear_rate", got.linear_rate, e.linear_rate);
			if (got.angular_rate !== e.angular_rate)
				report("angular_rate", got.angular_rate, e.angular_rate);
			results++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:2]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	qodo_if #(.item_t(in_item_t)) in_ch ();
	qodo_if #(.item_t(out_item_t)) out_ch ();

	quadrature_odometry dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	odometry_scoreboard sb = new();
	int          tx_idle = 0, rx_idle = 0;
	int          items = 0, reg_writes = 0;
	longint      cycles = 0;
	logic [31:0] now_ms = 0;
	int          lpos = 0, rpos = 0;
	logic [1:0]  gray [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (out_ch.valid && out_ch.ready) sb.check_pose(out_ch.data);
			out_ch.ready <= ($urandom_range(99) >= rx_idle);
			@(posedge clk);
		end
	end

	task send(in_item_t it);
		while ($urandom_range(99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_item(it);
		items++;
	endtask

	task pins(logic la, logic lb, logic ra, logic rb);
		in_item_t it;
		it = '0;
		it.opcode = OpPins;
		it.left_a = la; it.left_b = lb; it.right_a = ra; it.right_b = rb;
		it.now_ms = $urandom();
		send(it);
	endtask

	task update(logic [31:0] ms);
		in_item_t it;
		it.opcode = OpUpdate;
		it.left_a = 1'($urandom_range(1)); it.left_b = 1'($urandom_range(1));
		it.right_a = 1'($urandom_range(1)); it.right_b = 1'($urandom_range(1));
		it.now_ms = ms;
		now_ms = ms;
		send(it);
	endtask

	task drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.poses.size() != 0) @(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	task write_reg(logic [0:0] idx, logic [31:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= idx; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.write_reg(idx, v);
		reg_writes++;
	endtask

	task random_run(int n, int tx, int rx);
		int roll, pick;
		logic [1:0] lph, rph;
		tx_idle = tx; rx_idle = rx;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(99);
			if (k == n / 2) begin
				// hold off until every pending result is back
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (sb.poses.size() != 0) @(posedge clk);
			end
			if (roll < 16) begin
				pick = $urandom_range(99);
				if (pick < 10) update(now_ms);
				else if (pick < 14) update($urandom());
				else update(now_ms + $urandom_range(1, 200));
			end else begin
				// mostly legal gray steps, some noise
				if ($urandom_range(99) < 12) begin
					lph = 2'($urandom_range(3)); rph = 2'($urandom_range(3));
					lpos = (lph == 2'b00) ? 0 : (lph == 2'b01) ? 1 : (lph == 2'b11) ? 2 : 3;
					rpos = (rph == 2'b00) ? 0 : (rph == 2'b01) ? 1 : (rph == 2'b11) ? 2 : 3;
				end else begin
					lpos = (lpos + ($urandom_range(99) < 70 ? 1 : 3)) % 4;
					rpos = (rpos + ($urandom_range(99) < 60 ? 1 : 3)) % 4;
					if ($urandom_range(9) == 0) rpos = (rpos + 3) % 4;
					lph = gray[lpos]; rph = gray[rpos];
				end
				pins(lph[1], lph[0], rph[1], rph[0]);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		in_ch.valid <= 1'b0; in_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (Settle) @(posedge clk);

		// directed: equal time at start, every forward and reverse step, illegal steps, wraps
		update(32'd0);
		pins(0, 1, 1, 0); pins(1, 1, 1, 1); pins(1, 0, 0, 1); pins(0, 0, 0, 0);
		update(32'd1000);
		pins(1, 0, 0, 1); pins(1, 1, 1, 1); pins(0, 1, 1, 0); pins(0, 0, 0, 0);
		pins(1, 1, 1, 1); pins(0, 0, 0, 0); pins(0, 0, 0, 0);
		pins(0, 1, 1, 0); pins(1, 0, 0, 1);
		update(32'd1000);
		update(32'hFFFFFFFF);
		pins(1, 1, 0, 0); pins(0, 1, 1, 0);
		update(32'd5);
		update(32'd999);
		drain();

		write_reg(RegMpt, 32'hFFFFFFFF);
		write_reg(RegApt, 32'h00000000);
		random_run(230, 27, 79);
		drain();

		write_reg(RegMpt, 32'h00000000);
		write_reg(RegApt, 32'hFFFFFFFF);
		random_run(230, 79, 27);
		drain();

		write_reg(RegMpt, $urandom());
		write_reg(RegApt, $urandom_range(32'h00FFFFFF));
		random_run(230, 0, 0);
		drain();

		$display("covered %0d items, %0d results checked, %0d register writes",
			items, sb.results, reg_writes);
		$display("configs: reset values, both extremes and random; three idle patterns");
		if (sb.errors == 0 && sb.poses.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/qodo_pkg.sv
hdl/qodo_if.sv
hdl/qodo_cordic.sv
hdl/qodo_div.sv
hdl/quadrature_odometry.sv
dv/quadrature_odometry_tb.sv
